@@ design/discrete_log_bsgs_top_macros.svh @@
// ----------------------------------------------------------------------------
// Discrete log BSGS assertion macros
// Shared concurrent assertion forms for the discrete log block checkers.
// ----------------------------------------------------------------------------
`ifndef DISCRETE_LOG_BSGS_TOP_MACROS_SVH
`define DISCRETE_LOG_BSGS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dlb_pkg.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS package
// Constants, codes and shared types of the discrete logarithm block.
// ----------------------------------------------------------------------------
`default_nettype none

package dlb_pkg;

  localparam int RESIDUE_BITS = 16;
  localparam int TABLE_DEPTH  = 256;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int LOG_W      = 16;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ORDER = 2'd2;

  localparam logic [CFG_DATA_W-1:0] MODULUS_RST = 16'd2;
  localparam logic [CFG_DATA_W-1:0] BASE_RST    = 16'd1;
  localparam logic [CFG_DATA_W-1:0] ORDER_RST   = 16'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_INV  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_G,
    OP_SET_G,
    OP_RED_A,
    OP_SET_A,
    OP_EUC_INIT,
    OP_EUC_DIV,
    OP_EUC_STEP,
    OP_SET_INV,
    OP_K_STEP,
    OP_POW_INIT,
    OP_POW_MUL_R,
    OP_POW_SET_R,
    OP_POW_MUL_B,
    OP_POW_SET_B,
    OP_GF_INIT,
    OP_GF_MUL,
    OP_GF_SET,
    OP_SR_INIT,
    OP_SCAN,
    OP_BS_MUL,
    OP_BS_SET,
    OP_E_CALC,
    OP_E_MOD,
    OP_E_SET,
    OP_RES_OK,
    OP_RES_ERR1,
    OP_RES_ERR2
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic p_small;
    logic div_done;
    logic r1_zero;
    logic r0_one;
    logic k_more;
    logic e_zero;
    logic e_odd;
    logic gf_more;
    logic scan_done;
    logic bs_last;
    logic found;
    logic order_zero;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK_P,
    ST_G_W,
    ST_RED_A,
    ST_A_W,
    ST_EUC_I,
    ST_EUC,
    ST_EUC_W,
    ST_EUC_END,
    ST_K,
    ST_POW,
    ST_POW_RW,
    ST_POW_B,
    ST_POW_BW,
    ST_GF,
    ST_GF_W,
    ST_SCAN,
    ST_BS_W,
    ST_E,
    ST_E_M,
    ST_E_W,
    ST_RES,
    ST_ERR1,
    ST_ERR2
  } state_e;

endpackage

`default_nettype wire

@@ design/dlb_intf.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS channels
// Request, response and configuration write channels of the block.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlb_req_if;
  logic                            valid;
  logic                            ready;
  logic [dlb_pkg::CFG_DATA_W-1:0]  target_value;

  modport source (output valid, output target_value, input ready);
  modport sink   (input valid, input target_value, output ready);
endinterface

interface dlb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dlb_pkg::LOG_W-1:0]     log_value;
  logic [dlb_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output log_value, output status, input ready);
  modport sink   (input valid, input log_value, input status, output ready);
endinterface

interface dlb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dlb_pkg::CFG_IDX_W-1:0]   index;
  logic [dlb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/dlb_divider.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS divider
// Restoring divider giving one quotient bit per cycle, shared by all
// modular reductions and the extended Euclid steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dlb_divider #(
  parameter int NW  = 32,
  parameter int DNW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DNW-1:0] den_i,
  output logic           done_o,
  output logic [NW-1:0]  quot_o,
  output logic [DNW-1:0] rem_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   quot_q, quot_d;
  logic [DNW-1:0]  rem_q, rem_d;
  logic [DNW-1:0]  den_q, den_d;
  logic [DNW:0]    shifted;
  logic [DNW:0]    diff;

  assign shifted = {rem_q, quot_q[NW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(NW);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!diff[DNW]) begin
        rem_d  = diff[DNW-1:0];
        quot_d = {quot_q[NW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[DNW-1:0];
        quot_d = {quot_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ design/dlb_datapath.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS datapath
// Configuration registers, operand registers, giant step memory, the
// shared multiplier and divider, and the match scan.
// ----------------------------------------------------------------------------
`default_nettype none

module dlb_datapath #(
  parameter int W     = dlb_pkg::RESIDUE_BITS,
  parameter int DEPTH = dlb_pkg::TABLE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dlb_pkg::cmd_t                   cmd_i,
  output dlb_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [dlb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dlb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [dlb_pkg::CFG_DATA_W-1:0]  target_i,
  output logic [dlb_pkg::LOG_W-1:0]       log_o,
  output logic [dlb_pkg::STATUS_W-1:0]    status_o
);

  localparam int KW  = $clog2(DEPTH + 1);
  localparam int IW  = $clog2(DEPTH);
  localparam int TW  = W + 2;
  localparam int XW  = dlb_pkg::max2(W, dlb_pkg::CFG_DATA_W);
  localparam int DNW = XW;
  localparam int NW  = dlb_pkg::max2(dlb_pkg::max2(2 * W, 2 * KW), dlb_pkg::LOG_W);
  localparam int CW  = dlb_pkg::max2(2 * KW, W);

  logic [dlb_pkg::CFG_DATA_W-1:0] modulus_q, base_q, order_q;
  logic [XW-1:0] mod_x, base_x, tgt_x;

  logic [W-1:0]          p_q, g_q, a_q, r0_q, r1_q, ginv_q;
  logic signed [TW-1:0]  t0_q, t1_q;
  logic [KW-1:0]         k_q, pw_e_q, j_q, i_q;
  logic [W-1:0]          pw_r_q, pw_b_q, cur_q, rdata_q, best_res_q;
  logic [IW-1:0]         rj_q, best_i_q, best_j_q;
  logic                  rv_q, found_q;
  logic [NW-1:0]         e_q;
  logic [dlb_pkg::LOG_W-1:0]    log_q;
  logic [dlb_pkg::STATUS_W-1:0] status_q;

  logic [W-1:0] giant_mem [DEPTH];

  logic           div_start, div_done;
  logic [NW-1:0]  div_num, div_quot;
  logic [DNW-1:0] div_den, div_rem;
  logic [W-1:0]   rem_w, q_w;
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] prod;

  logic signed [W:0]      q_s;
  logic signed [W+TW:0]   qt;
  logic signed [TW-1:0]   t_next;
  logic signed [TW-1:0]   inv_a;
  logic [TW-1:0]          inv_u, inv_b;
  logic [2*KW-1:0]        ksq;
  logic [IW+KW-1:0]       jk;
  logic [KW-1:0]          i_nx;
  logic                   issue, hit;

  assign mod_x  = XW'(modulus_q);
  assign base_x = XW'(base_q);
  assign tgt_x  = XW'(target_i);

  assign rem_w = div_rem[W-1:0];
  assign q_w   = div_quot[W-1:0];

  always_comb begin
    mul_a = cur_q;
    mul_b = ginv_q;
    case (cmd_i.op)
      dlb_pkg::OP_POW_MUL_R: begin
        mul_a = pw_r_q;
        mul_b = pw_b_q;
      end
      dlb_pkg::OP_POW_MUL_B: begin
        mul_a = pw_b_q;
        mul_b = pw_b_q;
      end
      dlb_pkg::OP_GF_MUL: begin
        mul_a = cur_q;
        mul_b = pw_r_q;
      end
      default: begin
        mul_a = cur_q;
        mul_b = ginv_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_start = 1'b1;
    div_num   = NW'(prod);
    div_den   = DNW'(p_q);
    case (cmd_i.op)
      dlb_pkg::OP_RED_G:  div_num = NW'(g_q);
      dlb_pkg::OP_RED_A:  div_num = NW'(a_q);
      dlb_pkg::OP_EUC_DIV: begin
        div_num = NW'(r0_q);
        div_den = DNW'(r1_q);
      end
      dlb_pkg::OP_POW_MUL_R, dlb_pkg::OP_POW_MUL_B,
      dlb_pkg::OP_GF_MUL, dlb_pkg::OP_BS_MUL: div_num = NW'(prod);
      dlb_pkg::OP_E_MOD: begin
        div_num = e_q;
        div_den = DNW'(order_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  dlb_divider #(
    .NW  (NW),
    .DNW (DNW)
  ) u_dlb_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign q_s    = $signed({1'b0, q_w});
  assign qt     = q_s * t1_q;
  assign t_next = t0_q - $signed(qt[TW-1:0]);

  assign inv_a = t0_q[TW-1] ? (t0_q + $signed(TW'(p_q))) : t0_q;
  assign inv_u = inv_a;
  assign inv_b = (inv_u >= TW'(p_q)) ? (inv_u - TW'(p_q)) : inv_u;

  assign ksq  = k_q * k_q;
  assign jk   = best_j_q * k_q;
  assign i_nx = i_q + KW'(1);

  assign issue = (cmd_i.op == dlb_pkg::OP_SCAN) && (j_q < k_q);
  assign hit   = rv_q && (rdata_q == cur_q) && (!found_q || (cur_q < best_res_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= dlb_pkg::MODULUS_RST;
      base_q    <= dlb_pkg::BASE_RST;
      order_q   <= dlb_pkg::ORDER_RST;
      rv_q      <= 1'b0;
    end else begin
      rv_q <= issue;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dlb_pkg::CFG_MODULUS:     modulus_q <= cfg_data_i;
          dlb_pkg::CFG_BASE:        base_q    <= cfg_data_i;
          dlb_pkg::CFG_GROUP_ORDER: order_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dlb_pkg::OP_GF_INIT) begin
      giant_mem[0] <= W'(1);
    end else if (cmd_i.op == dlb_pkg::OP_GF_SET) begin
      giant_mem[j_q[IW-1:0]] <= rem_w;
    end
    if (issue) begin
      rdata_q <= giant_mem[j_q[IW-1:0]];
      rj_q    <= j_q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      dlb_pkg::OP_LOAD: begin
        p_q <= mod_x[W-1:0];
        g_q <= base_x[W-1:0];
        a_q <= tgt_x[W-1:0];
      end
      dlb_pkg::OP_SET_G: g_q <= rem_w;
      dlb_pkg::OP_SET_A: a_q <= rem_w;
      dlb_pkg::OP_EUC_INIT: begin
        r0_q <= p_q;
        r1_q <= g_q;
        t0_q <= '0;
        t1_q <= TW'(1);
      end
      dlb_pkg::OP_EUC_STEP: begin
        r0_q <= r1_q;
        r1_q <= rem_w;
        t0_q <= t1_q;
        t1_q <= t_next;
      end
      dlb_pkg::OP_SET_INV: begin
        ginv_q <= inv_b[W-1:0];
        k_q    <= '0;
      end
      dlb_pkg::OP_K_STEP: k_q <= k_q + KW'(1);
      dlb_pkg::OP_POW_INIT: begin
        pw_r_q <= W'(1);
        pw_b_q <= g_q;
        pw_e_q <= k_q;
      end
      dlb_pkg::OP_POW_SET_R: pw_r_q <= rem_w;
      dlb_pkg::OP_POW_SET_B: begin
        pw_b_q <= rem_w;
        pw_e_q <= pw_e_q >> 1;
      end
      dlb_pkg::OP_GF_INIT: begin
        cur_q <= W'(1);
        j_q   <= KW'(1);
      end
      dlb_pkg::OP_GF_SET: begin
        cur_q <= rem_w;
        j_q   <= j_q + KW'(1);
      end
      dlb_pkg::OP_SR_INIT: begin
        cur_q   <= a_q;
        i_q     <= '0;
        j_q     <= '0;
        found_q <= 1'b0;
      end
      dlb_pkg::OP_SCAN: begin
        if (issue) begin
          j_q <= j_q + KW'(1);
        end
      end
      dlb_pkg::OP_BS_SET: begin
        cur_q <= rem_w;
        i_q   <= i_nx;
        j_q   <= '0;
      end
      dlb_pkg::OP_E_CALC: e_q <= NW'(best_i_q) + NW'(jk);
      dlb_pkg::OP_E_SET:  e_q <= NW'(div_rem);
      dlb_pkg::OP_RES_OK: begin
        log_q    <= e_q[dlb_pkg::LOG_W-1:0];
        status_q <= dlb_pkg::STATUS_OK;
      end
      dlb_pkg::OP_RES_ERR1: begin
        log_q    <= '0;
        status_q <= dlb_pkg::STATUS_NOT_INV;
      end
      dlb_pkg::OP_RES_ERR2: begin
        log_q    <= '0;
        status_q <= dlb_pkg::STATUS_NO_MATCH;
      end
      default: ;
    endcase
    if (hit) begin
      best_res_q <= cur_q;
      best_i_q   <= i_q[IW-1:0];
      best_j_q   <= rj_q;
      found_q    <= 1'b1;
    end
  end

  always_comb begin
    sts_o.p_small    = (p_q < W'(2));
    sts_o.div_done   = div_done;
    sts_o.r1_zero    = (r1_q == '0);
    sts_o.r0_one     = (r0_q == W'(1));
    sts_o.k_more     = (CW'(ksq) < CW'(p_q)) && (k_q < KW'(DEPTH));
    sts_o.e_zero     = (pw_e_q == '0);
    sts_o.e_odd      = pw_e_q[0];
    sts_o.gf_more    = (j_q < k_q);
    sts_o.scan_done  = (j_q == k_q) && !rv_q;
    sts_o.bs_last    = (i_nx == k_q);
    sts_o.found      = found_q;
    sts_o.order_zero = (order_q == '0);
  end

  assign log_o    = log_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

@@ design/dlb_controller.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS controller
// Sequences one request through reduction, inversion, table build, match
// scan and final reduction, and owns the handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module dlb_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output dlb_pkg::cmd_t  cmd_o,
  input  dlb_pkg::sts_t  sts_i
);

  dlb_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = dlb_pkg::OP_NONE;
    req_ready_o = 1'b0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    case (state_q)
      dlb_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = dlb_pkg::OP_LOAD;
          state_d  = dlb_pkg::ST_CHK_P;
        end
      end
      dlb_pkg::ST_CHK_P: begin
        if (sts_i.p_small) begin
          state_d = dlb_pkg::ST_ERR1;
        end else begin
          cmd_o.op = dlb_pkg::OP_RED_G;
          state_d  = dlb_pkg::ST_G_W;
        end
      end
      dlb_pkg::ST_G_W: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_SET_G;
          state_d  = dlb_pkg::ST_RED_A;
        end
      end
      dlb_pkg::ST_RED_A: begin
        cmd_o.op = dlb_pkg::OP_RED_A;
        state_d  = dlb_pkg::ST_A_W;
      end
      dlb_pkg::ST_A_W: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_SET_A;
          state_d  = dlb_pkg::ST_EUC_I;
        end
      end
      dlb_pkg::ST_EUC_I: begin
        cmd_o.op = dlb_pkg::OP_EUC_INIT;
        state_d  = dlb_pkg::ST_EUC;
      end
      dlb_pkg::ST_EUC: begin
        if (sts_i.r1_zero) begin
          state_d = dlb_pkg::ST_EUC_END;
        end else begin
          cmd_o.op = dlb_pkg::OP_EUC_DIV;
          state_d  = dlb_pkg::ST_EUC_W;
        end
      end
      dlb_pkg::ST_EUC_W: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_EUC_STEP;
          state_d  = dlb_pkg::ST_EUC;
        end
      end
      dlb_pkg::ST_EUC_END: begin
        if (!sts_i.r0_one) begin
          state_d = dlb_pkg::ST_ERR1;
        end else begin
          cmd_o.op = dlb_pkg::OP_SET_INV;
          state_d  = dlb_pkg::ST_K;
        end
      end
      dlb_pkg::ST_K: begin
        if (sts_i.k_more) begin
          cmd_o.op = dlb_pkg::OP_K_STEP;
        end else begin
          cmd_o.op = dlb_pkg::OP_POW_INIT;
          state_d  = dlb_pkg::ST_POW;
        end
      end
      dlb_pkg::ST_POW: begin
        if (sts_i.e_zero) begin
          cmd_o.op = dlb_pkg::OP_GF_INIT;
          state_d  = dlb_pkg::ST_GF;
        end else if (sts_i.e_odd) begin
          cmd_o.op = dlb_pkg::OP_POW_MUL_R;
          state_d  = dlb_pkg::ST_POW_RW;
        end else begin
          cmd_o.op = dlb_pkg::OP_POW_MUL_B;
          state_d  = dlb_pkg::ST_POW_BW;
        end
      end
      dlb_pkg::ST_POW_RW: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_POW_SET_R;
          state_d  = dlb_pkg::ST_POW_B;
        end
      end
      dlb_pkg::ST_POW_B: begin
        cmd_o.op = dlb_pkg::OP_POW_MUL_B;
        state_d  = dlb_pkg::ST_POW_BW;
      end
      dlb_pkg::ST_POW_BW: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_POW_SET_B;
          state_d  = dlb_pkg::ST_POW;
        end
      end
      dlb_pkg::ST_GF: begin
        if (sts_i.gf_more) begin
          cmd_o.op = dlb_pkg::OP_GF_MUL;
          state_d  = dlb_pkg::ST_GF_W;
        end else begin
          cmd_o.op = dlb_pkg::OP_SR_INIT;
          state_d  = dlb_pkg::ST_SCAN;
        end
      end
      dlb_pkg::ST_GF_W: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_GF_SET;
          state_d  = dlb_pkg::ST_GF;
        end
      end
      dlb_pkg::ST_SCAN: begin
        if (!sts_i.scan_done) begin
          cmd_o.op = dlb_pkg::OP_SCAN;
        end else if (sts_i.bs_last) begin
          state_d = dlb_pkg::ST_E;
        end else begin
          cmd_o.op = dlb_pkg::OP_BS_MUL;
          state_d  = dlb_pkg::ST_BS_W;
        end
      end
      dlb_pkg::ST_BS_W: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_BS_SET;
          state_d  = dlb_pkg::ST_SCAN;
        end
      end
      dlb_pkg::ST_E: begin
        if (!sts_i.found) begin
          state_d = dlb_pkg::ST_ERR2;
        end else begin
          cmd_o.op = dlb_pkg::OP_E_CALC;
          state_d  = dlb_pkg::ST_E_M;
        end
      end
      dlb_pkg::ST_E_M: begin
        if (sts_i.order_zero) begin
          state_d = dlb_pkg::ST_RES;
        end else begin
          cmd_o.op = dlb_pkg::OP_E_MOD;
          state_d  = dlb_pkg::ST_E_W;
        end
      end
      dlb_pkg::ST_E_W: begin
        if (sts_i.div_done) begin
          cmd_o.op = dlb_pkg::OP_E_SET;
          state_d  = dlb_pkg::ST_RES;
        end
      end
      dlb_pkg::ST_RES: begin
        if (out_free) begin
          cmd_o.op    = dlb_pkg::OP_RES_OK;
          out_valid_d = 1'b1;
          state_d     = dlb_pkg::ST_IDLE;
        end
      end
      dlb_pkg::ST_ERR1: begin
        if (out_free) begin
          cmd_o.op    = dlb_pkg::OP_RES_ERR1;
          out_valid_d = 1'b1;
          state_d     = dlb_pkg::ST_IDLE;
        end
      end
      dlb_pkg::ST_ERR2: begin
        if (out_free) begin
          cmd_o.op    = dlb_pkg::OP_RES_ERR2;
          out_valid_d = 1'b1;
          state_d     = dlb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dlb_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/discrete_log_bsgs_top.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS top level
// Baby-step giant-step discrete logarithm engine with a configuration port.
// ----------------------------------------------------------------------------
// Each request is worked on alone. Every modular product and reduction goes
// through one shared restoring divider of NW = max(2*RESIDUE_BITS,
// 2*ceil(log2(TABLE_DEPTH + 1)), 16) quotient bits (32 at the defaults). The
// match scan compares every baby step against the stored giant steps at one
// memory read per cycle, with k = min(ceil(sqrt(modulus)), TABLE_DEPTH) giant
// steps in the table. A finished result waits in the output register while the
// next request is already accepted.
`default_nettype none

module discrete_log_bsgs_top #(
  parameter int RESIDUE_BITS = dlb_pkg::RESIDUE_BITS,
  parameter int TABLE_DEPTH  = dlb_pkg::TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dlb_cfg_if.sink     cfg_i,
  dlb_req_if.sink     req_i,
  dlb_rsp_if.source   rsp_o
);

  dlb_pkg::cmd_t cmd;
  dlb_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  dlb_controller u_dlb_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dlb_datapath #(
    .W     (RESIDUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_dlb_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .target_i   (req_i.target_value),
    .log_o      (rsp_o.log_value),
    .status_o   (rsp_o.status)
  );

endmodule

`default_nettype wire

@@ design/dlb_checker.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS checker
// Port level checks of request and response ordering and result coding.
// ----------------------------------------------------------------------------
`default_nettype none

`include "discrete_log_bsgs_top_macros.svh"

module dlb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  logic                            rsp_valid_i,
  input  logic                            rsp_ready_i,
  input  logic [dlb_pkg::LOG_W-1:0]       log_value_i,
  input  logic [dlb_pkg::STATUS_W-1:0]    status_i
);

  logic [1:0] pend_q;
  logic       req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (req_acc && !rsp_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (rsp_acc && !req_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `DLB_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
    rsp_valid_i && $stable(log_value_i) && $stable(status_i), "stalled response changed")
  `DLB_ASSERT_IMP(a_rsp_has_req, clk_i, rst_ni, rsp_valid_i, pend_q != 2'd0,
    "response without an outstanding request")
  `DLB_ASSERT_IMP(a_req_bound, clk_i, rst_ni, req_acc, pend_q != 2'd2,
    "request accepted with two requests outstanding")
  `DLB_ASSERT_IMP(a_err_zero, clk_i, rst_ni, rsp_valid_i && (status_i != dlb_pkg::STATUS_OK),
    log_value_i == '0, "error response carries a non-zero logarithm")
  `DLB_ASSERT_IMP(a_status_code, clk_i, rst_ni, rsp_valid_i,
    (status_i == dlb_pkg::STATUS_OK) || (status_i == dlb_pkg::STATUS_NOT_INV) ||
    (status_i == dlb_pkg::STATUS_NO_MATCH), "undefined status code")

endmodule

bind discrete_log_bsgs_top dlb_checker u_dlb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .log_value_i (rsp_o.log_value),
  .status_i    (rsp_o.status)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Discrete log BSGS testbench
// Drives residues through the request channel under several modulus, base and
// group order settings, checks each response against a listed answer or a
// behavioural BSGS predictor, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int HOLD_CYCLES    = 20000;

  typedef struct {
    logic [15:0] modulus;
    logic [15:0] base;
    logic [15:0] order;
    logic [15:0] target;
    bit          typed;
    logic [15:0] log_val;
    logic [1:0]  status;
  } row_t;

  typedef struct {
    logic [15:0] log_val;
    logic [1:0]  status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dlb_cfg_if cfg_if ();
  dlb_req_if req_if ();
  dlb_rsp_if rsp_if ();

  discrete_log_bsgs_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  logic [15:0] modulus_q = dlb_pkg::MODULUS_RST;
  logic [15:0] base_q    = dlb_pkg::BASE_RST;
  logic [15:0] order_q   = dlb_pkg::ORDER_RST;

  answer_t pending_answers[$];
  int mismatches = 0;
  int answers_seen = 0;
  int requests_sent = 0;
  int errors_seen = 0;
  int watchdog = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  row_t rows[$];

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = (r * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic answer_t bsgs_answer(logic [15:0] target);
    answer_t ans;
    longint unsigned p, g, a, ginv, k, gk, best, e;
    longint r0, r1, t0, t1, q, tmp;
    longint unsigned baby[256];
    longint unsigned giant[256];
    int bi, gj;
    ans.log_val = '0;
    ans.status = dlb_pkg::STATUS_NOT_INV;
    p = modulus_q;
    if (p < 2) return ans;
    g = base_q % p;
    a = target % p;
    r0 = p; r1 = g; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) return ans;
    if (t0 < 0) t0 = t0 + longint'(p);
    ginv = longint'(t0) % p;
    k = 0;
    while (k * k < p) k++;
    if (k > dlb_pkg::TABLE_DEPTH) k = dlb_pkg::TABLE_DEPTH;
    gk = pow_mod(g, k, p);
    baby[0] = a;
    giant[0] = 1 % p;
    for (int i = 1; i < k; i++) begin
      baby[i] = (baby[i-1] * ginv) % p;
      giant[i] = (giant[i-1] * gk) % p;
    end
    best = 64'hFFFF_FFFF;
    for (int i = 0; i < k; i++)
      for (int j = 0; j < k; j++)
        if (baby[i] == giant[j] && baby[i] < best) best = baby[i];
    if (best == 64'hFFFF_FFFF) begin
      ans.status = dlb_pkg::STATUS_NO_MATCH;
      return ans;
    end
    bi = -1; gj = -1;
    for (int i = k - 1; i >= 0; i--) begin
      if (baby[i] == best) bi = i;
      if (giant[i] == best) gj = i;
    end
    e = bi + gj * k;
    if (order_q != 0) e = e % order_q;
    ans.log_val = e[15:0];
    ans.status = dlb_pkg::STATUS_OK;
    return ans;
  endfunction

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dlb_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      dlb_pkg::CFG_MODULUS: modulus_q = value;
      dlb_pkg::CFG_BASE:    base_q = value;
      default:              order_q = value;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] m, logic [15:0] g, logic [15:0] o);
    if (m == modulus_q && g == base_q && o == order_q) return;
    wait_drained();
    if (m != modulus_q) write_reg(dlb_pkg::CFG_MODULUS, m);
    if (g != base_q) write_reg(dlb_pkg::CFG_BASE, g);
    if (o != order_q) write_reg(dlb_pkg::CFG_GROUP_ORDER, o);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_request(logic [15:0] target, bit typed, answer_t typed_ans);
    answer_t ans;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.target_value <= target;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    ans = typed ? typed_ans : bsgs_answer(target);
    pending_answers.push_back(ans);
    requests_sent++;
    if (ans.status != dlb_pkg::STATUS_OK) errors_seen++;
  endtask

  task automatic add_row(logic [15:0] m, logic [15:0] g, logic [15:0] o, logic [15:0] t,
                         bit typed = 0, logic [15:0] lv = 0,
                         logic [1:0] st = dlb_pkg::STATUS_OK);
    row_t r;
    r.modulus = m; r.base = g; r.order = o; r.target = t;
    r.typed = typed; r.log_val = lv; r.status = st;
    rows.push_back(r);
  endtask

  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      answer_t want;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response: log %0d status %0d",
                                       rsp_if.log_value, rsp_if.status);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.log_value !== want.log_val || rsp_if.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected log %0d status %0d, got log %0d status %0d",
                     want.log_val, want.status, rsp_if.log_value, rsp_if.status);
        end
      end
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
        rsp_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d responses outstanding",
                 pending_answers.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    answer_t none;
    answer_t typed_ans;
    logic [15:0] m, g, o, t;
    none.log_val = '0;
    none.status = dlb_pkg::STATUS_OK;
    req_if.valid = 1'b0;
    req_if.target_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = dlb_pkg::CFG_MODULUS;
    cfg_if.data = '0;

    add_row(16'd2, 16'd1, 16'd1, 16'd0, 1, 16'd0, dlb_pkg::STATUS_NO_MATCH);
    add_row(16'd2, 16'd1, 16'd1, 16'd1, 1, 16'd0, dlb_pkg::STATUS_OK);
    add_row(16'd2, 16'd1, 16'd1, 16'hFFFF, 1, 16'd0, dlb_pkg::STATUS_OK);
    add_row(16'd0, 16'd5, 16'd1, 16'd3, 1, 16'd0, dlb_pkg::STATUS_NOT_INV);
    add_row(16'd1, 16'd5, 16'd1, 16'hFFFF, 1, 16'd0, dlb_pkg::STATUS_NOT_INV);
    add_row(16'd11, 16'd0, 16'd10, 16'd4, 1, 16'd0, dlb_pkg::STATUS_NOT_INV);
    add_row(16'd12, 16'd4, 16'd4, 16'd4, 1, 16'd0, dlb_pkg::STATUS_NOT_INV);
    add_row(16'd11, 16'd2, 16'd10, 16'd1, 1, 16'd0, dlb_pkg::STATUS_OK);
    add_row(16'd11, 16'd2, 16'd10, 16'd2);
    add_row(16'd11, 16'd2, 16'd10, 16'd13);
    add_row(16'd11, 16'd2, 16'd10, 16'd0);
    add_row(16'd11, 16'd2, 16'd10, 16'hFFFF);
    add_row(16'd11, 16'd13, 16'd0, 16'd5);
    add_row(16'd11, 16'd13, 16'd0, 16'd9);
    add_row(16'd7, 16'd2, 16'd6, 16'd3);
    add_row(16'd7, 16'd2, 16'd6, 16'd4);
    add_row(16'd65535, 16'd65535, 16'd0, 16'd7, 1, 16'd0, dlb_pkg::STATUS_NOT_INV);
    add_row(16'd65521, 16'd17, 16'd65520, 16'd12345);
    add_row(16'd65535, 16'd2, 16'd65535, 16'h8000);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[n]) begin
      apply_settings(rows[n].modulus, rows[n].base, rows[n].order);
      typed_ans.log_val = rows[n].log_val;
      typed_ans.status = rows[n].status;
      send_request(rows[n].target, rows[n].typed, rows[n].typed ? typed_ans : none);
    end

    for (int item = 0; item < 100; ) begin
      case ($urandom_range(0, 9))
        0:       m = 16'($urandom_range(0, 1));
        1:       m = 16'($urandom_range(2, 16));
        default: m = 16'($urandom_range(17, 1024));
      endcase
      g = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
      case ($urandom_range(0, 3))
        0:       o = 16'd0;
        1:       o = 16'($urandom);
        default: o = (m > 1) ? m - 16'd1 : 16'd1;
      endcase
      apply_settings(m, g, o);
      for (int n = 0; n < 10 && item < 100; n++, item++) begin
        if (item == 30) hold_off = 1'b1;
        if (item == 60) wait_drained();
        if (item >= 85) quiet = 1'b1;
        if ($urandom_range(0, 3) == 0 || m < 2)
          t = 16'($urandom);
        else
          t = 16'(pow_mod(g, $urandom_range(0, 65535), m)) +
              16'(m * $urandom_range(0, 65535 / m));
        send_request(t, 0, none);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests over several modulus settings; %0d responses checked,",
             requests_sent, answers_seen);
    $display("%0d of them error responses, %0d mismatches.", errors_seen, mismatches);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/dlb_pkg.sv
design/dlb_intf.sv
design/dlb_divider.sv
design/dlb_datapath.sv
design/dlb_controller.sv
design/discrete_log_bsgs_top.sv
design/dlb_checker.sv
tb/tb.sv
